@@ hw/rtl/vn2d_pkg.sv @@
// ----------------------------------------------------------------------------
// vn2d_pkg: shared constants and types for the 2D value noise block.
// Holds the command codes, the fixed field widths, the parameter defaults
// and the beat record that carries one command down the table pipeline.
// ----------------------------------------------------------------------------
package vn2d_pkg;

    // Fixed field widths of the command and result beats.
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 8;
    localparam int DATA_W  = 16;
    localparam int VALUE_W = 16;
    localparam int PERM_W  = 8;
    localparam int COORD_W = 32;

    // Parameter defaults.
    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD_VALUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_PERM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL       = 2'd2;

    // One accepted beat as it travels through the table stages.
    typedef struct packed {
        logic               eval;
        logic               value_we;
        logic               perm_we;
        logic [INDEX_W-1:0] index;
        logic [DATA_W-1:0]  data;
    } t_beat;

endpackage

@@ hw/rtl/value_noise_2d.sv @@
// ----------------------------------------------------------------------------
// value_noise_2d: seven-stage 2D value noise pipeline, one command beat per cycle.
// Each evaluate beat yields one result beat, marked by o_valid, in acceptance order.
// Throughput: one beat per cycle; busy stays low because the results cannot stall.
// Reset: synchronous i_rst_n clears all valid bits; tables stay undefined until loaded.
// ----------------------------------------------------------------------------
module value_noise_2d #(
    parameter int TABLE_SIZE = vn2d_pkg::TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = vn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [vn2d_pkg::CMD_W-1:0]          i_command,
    input  logic [vn2d_pkg::INDEX_W-1:0]        i_table_index,
    input  logic [vn2d_pkg::DATA_W-1:0]         i_table_data,
    input  logic signed [vn2d_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [vn2d_pkg::COORD_W-1:0] i_y_coord,
    output logic                                o_valid,
    output logic [vn2d_pkg::VALUE_W-1:0]        o_noise_value
);

    import vn2d_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);

    logic               w_accept;
    t_beat              w_beat;
    logic signed [63:0] w_xs;
    logic signed [63:0] w_ys;
    logic [IW-1:0]      w_cx0;
    logic [IW-1:0]      w_cx1;
    logic [IW-1:0]      w_cy0;
    logic [IW-1:0]      w_cy1;
    logic [FRAC_BITS:0] w_sx;
    logic [FRAC_BITS:0] w_sy;
    logic               w_eval3;
    logic [VALUE_W-1:0] w_c00;
    logic [VALUE_W-1:0] w_c10;
    logic [VALUE_W-1:0] w_c01;
    logic [VALUE_W-1:0] w_c11;

    // The pipeline never holds off a beat.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Decode the command beat.
    assign w_beat.eval     = w_accept && (i_command == CMD_EVAL);
    assign w_beat.value_we = w_accept && (i_command == CMD_LOAD_VALUE);
    assign w_beat.perm_we  = w_accept && (i_command == CMD_LOAD_PERM);
    assign w_beat.index    = i_table_index;
    assign w_beat.data     = i_table_data;

    // Floor the coordinates to wrapped cells; the fraction is the low bits.
    assign w_xs  = 64'(i_x_coord);
    assign w_ys  = 64'(i_y_coord);
    assign w_cx0 = w_xs[FRAC_BITS +: IW];
    assign w_cy0 = w_ys[FRAC_BITS +: IW];
    assign w_cx1 = w_cx0 + IW'(1);
    assign w_cy1 = w_cy0 + IW'(1);

    // Table lookups, three stages.
    vn2d_lookup #(.TABLE_SIZE(TABLE_SIZE)) u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_beat),
        .i_cx0   (w_cx0),
        .i_cx1   (w_cx1),
        .i_cy0   (w_cy0),
        .i_cy1   (w_cy1),
        .o_eval  (w_eval3),
        .o_c00   (w_c00),
        .o_c10   (w_c10),
        .o_c01   (w_c01),
        .o_c11   (w_c11)
    );

    // Smoothstep of both fractions, aligned with the corner values.
    vn2d_smooth #(.FRAC_BITS(FRAC_BITS)) u_smooth_x (
        .i_clk    (i_clk),
        .i_frac   (i_x_coord[FRAC_BITS-1:0]),
        .o_smooth (w_sx)
    );

    vn2d_smooth #(.FRAC_BITS(FRAC_BITS)) u_smooth_y (
        .i_clk    (i_clk),
        .i_frac   (i_y_coord[FRAC_BITS-1:0]),
        .o_smooth (w_sy)
    );

    // Bilinear interpolation, four stages.
    vn2d_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_eval3),
        .i_c00         (w_c00),
        .i_c10         (w_c10),
        .i_c01         (w_c01),
        .i_c11         (w_c11),
        .i_sx          (w_sx),
        .i_sy          (w_sy),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value)
    );

endmodule

@@ hw/rtl/vn2d_ram.sv @@
// ----------------------------------------------------------------------------
// vn2d_ram: generic single-write, single-read RAM.
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module vn2d_ram #(
    parameter int WIDTH = vn2d_pkg::VALUE_W,
    parameter int DEPTH = vn2d_pkg::TABLE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/vn2d_smooth.sv @@
// ----------------------------------------------------------------------------
// vn2d_smooth: pipelined smoothstep s = t*t*(3-2t) in fixed point.
// Three register stages: input fraction, square, then the weighted product.
// ----------------------------------------------------------------------------
module vn2d_smooth #(
    parameter int FRAC_BITS = vn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic [FRAC_BITS-1:0] i_frac,
    output logic [FRAC_BITS:0]   o_smooth
);

    localparam int F = FRAC_BITS;
    localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;

    logic [F-1:0]   r_t;
    logic [F-1:0]   r_t_d;
    logic [F-1:0]   r_t2;
    logic [F:0]     r_s;
    logic [2*F-1:0] w_sq;
    logic [F+1:0]   w_weight;
    logic [2*F+1:0] w_prod;

    // The square keeps its upper half; t*t stays below one.
    assign w_sq = r_t * r_t;

    // The weight 3 - 2t lies in (1, 3].
    assign w_weight = THREE_ONE - {1'b0, r_t_d, 1'b0};
    assign w_prod   = (2*F+2)'(r_t2) * (2*F+2)'(w_weight);

    // Pipeline registers; all payload, no reset needed.
    always_ff @(posedge i_clk) begin
        r_t   <= i_frac;
        r_t_d <= r_t;
        r_t2  <= w_sq[2*F-1:F];
        r_s   <= w_prod[F +: F+1];
    end

    assign o_smooth = r_s;

endmodule

@@ hw/rtl/vn2d_lookup.sv @@
// ----------------------------------------------------------------------------
// vn2d_lookup: table stages of the noise pipeline.
// Reads the permutation table at both x corners, hashes the four corners
// through a second permutation read, and fetches the four corner values.
// Every table copy is written at the stage where it is read, so loads and
// evaluations keep their program order.
// ----------------------------------------------------------------------------
module vn2d_lookup #(
    parameter int TABLE_SIZE = vn2d_pkg::TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vn2d_pkg::t_beat               i_beat,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_cx0,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_cx1,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_cy0,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_cy1,
    output logic                          o_eval,
    output logic [vn2d_pkg::VALUE_W-1:0]  o_c00,
    output logic [vn2d_pkg::VALUE_W-1:0]  o_c10,
    output logic [vn2d_pkg::VALUE_W-1:0]  o_c01,
    output logic [vn2d_pkg::VALUE_W-1:0]  o_c11
);

    import vn2d_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);

    // Reduce an 8-bit index or entry modulo the table size.
    function automatic logic [IW-1:0] to_idx(input logic [7:0] v);
        logic [IW+7:0] ext;
        ext = {{IW{1'b0}}, v};
        return ext[IW-1:0];
    endfunction

    t_beat             r_s1_beat;
    t_beat             r_s2_beat;
    logic              r_s3_eval;
    logic [IW-1:0]     r_s1_cy0;
    logic [IW-1:0]     r_s1_cy1;
    logic [PERM_W-1:0] w_pa0;
    logic [PERM_W-1:0] w_pa1;
    logic [IW-1:0]     w_px0;
    logic [IW-1:0]     w_px1;
    logic [IW-1:0]     w_hash_addr [4];
    logic [PERM_W-1:0] w_hash [4];
    logic [VALUE_W-1:0] w_val [4];

    // Stage 0: first permutation read at both x corners.
    vn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_x0 (
        .i_clk   (i_clk),
        .i_we    (i_beat.perm_we),
        .i_waddr (to_idx(i_beat.index)),
        .i_wdata (i_beat.data[PERM_W-1:0]),
        .i_raddr (i_cx0),
        .o_rdata (w_pa0)
    );

    vn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_x1 (
        .i_clk   (i_clk),
        .i_we    (i_beat.perm_we),
        .i_waddr (to_idx(i_beat.index)),
        .i_wdata (i_beat.data[PERM_W-1:0]),
        .i_raddr (i_cx1),
        .o_rdata (w_pa1)
    );

    // Beat and y corners follow the first read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_beat <= '0;
            r_s2_beat <= '0;
            r_s3_eval <= 1'b0;
        end else begin
            r_s1_beat <= i_beat;
            r_s2_beat <= r_s1_beat;
            r_s3_eval <= r_s2_beat.eval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cy0 <= i_cy0;
        r_s1_cy1 <= i_cy1;
    end

    // Stage 1: corner hash addresses, wrapping at the table size.
    assign w_px0 = to_idx(w_pa0);
    assign w_px1 = to_idx(w_pa1);
    assign w_hash_addr[0] = w_px0 + r_s1_cy0;
    assign w_hash_addr[1] = w_px1 + r_s1_cy0;
    assign w_hash_addr[2] = w_px0 + r_s1_cy1;
    assign w_hash_addr[3] = w_px1 + r_s1_cy1;

    // Stages 1 and 2: second permutation read and value read per corner.
    for (genvar g = 0; g < 4; g++) begin : g_corner
        vn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_hash (
            .i_clk   (i_clk),
            .i_we    (r_s1_beat.perm_we),
            .i_waddr (to_idx(r_s1_beat.index)),
            .i_wdata (r_s1_beat.data[PERM_W-1:0]),
            .i_raddr (w_hash_addr[g]),
            .o_rdata (w_hash[g])
        );

        vn2d_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_SIZE)) u_value (
            .i_clk   (i_clk),
            .i_we    (r_s2_beat.value_we),
            .i_waddr (to_idx(r_s2_beat.index)),
            .i_wdata (r_s2_beat.data),
            .i_raddr (to_idx(w_hash[g])),
            .o_rdata (w_val[g])
        );
    end

    assign o_eval = r_s3_eval;
    assign o_c00  = w_val[0];
    assign o_c10  = w_val[1];
    assign o_c01  = w_val[2];
    assign o_c11  = w_val[3];

endmodule

@@ hw/rtl/vn2d_interp.sv @@
// ----------------------------------------------------------------------------
// vn2d_interp: pipelined bilinear interpolation of the corner values.
// Each lerp is a + floor((b - a) * s), one multiply stage and one add stage:
// first both x lerps side by side, then the y lerp.
// ----------------------------------------------------------------------------
module vn2d_interp #(
    parameter int FRAC_BITS = vn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [vn2d_pkg::VALUE_W-1:0] i_c00,
    input  logic [vn2d_pkg::VALUE_W-1:0] i_c10,
    input  logic [vn2d_pkg::VALUE_W-1:0] i_c01,
    input  logic [vn2d_pkg::VALUE_W-1:0] i_c11,
    input  logic [FRAC_BITS:0]           i_sx,
    input  logic [FRAC_BITS:0]           i_sy,
    output logic                         o_valid,
    output logic [vn2d_pkg::VALUE_W-1:0] o_noise_value
);

    import vn2d_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int PW = F + 19;

    logic signed [16:0]   w_dx0;
    logic signed [16:0]   w_dx1;
    logic signed [F+1:0]  w_sx;
    logic signed [PW-1:0] w_px0;
    logic signed [PW-1:0] w_px1;
    logic                 r_a_valid;
    logic [VALUE_W-1:0]   r_a_c00;
    logic [VALUE_W-1:0]   r_a_c01;
    logic signed [PW-1:0] r_a_p0;
    logic signed [PW-1:0] r_a_p1;
    logic [F:0]           r_a_sy;
    logic [17:0]          w_sum0;
    logic [17:0]          w_sum1;
    logic                 r_b_valid;
    logic [VALUE_W-1:0]   r_b_n0;
    logic [VALUE_W-1:0]   r_b_n1;
    logic [F:0]           r_b_sy;
    logic signed [16:0]   w_dy;
    logic signed [F+1:0]  w_sy;
    logic signed [PW-1:0] w_py;
    logic                 r_c_valid;
    logic [VALUE_W-1:0]   r_c_n0;
    logic signed [PW-1:0] r_c_py;
    logic [17:0]          w_sum;
    logic                 r_d_valid;
    logic [VALUE_W-1:0]   r_d_noise;

    // Stage A: x differences times sx.
    assign w_dx0 = signed'({1'b0, i_c10}) - signed'({1'b0, i_c00});
    assign w_dx1 = signed'({1'b0, i_c11}) - signed'({1'b0, i_c01});
    assign w_sx  = signed'({1'b0, i_sx});
    assign w_px0 = PW'(w_dx0) * PW'(w_sx);
    assign w_px1 = PW'(w_dx1) * PW'(w_sx);

    // Stage B: add the floored products to the left corners.
    assign w_sum0 = {2'b00, r_a_c00} + r_a_p0[F +: 18];
    assign w_sum1 = {2'b00, r_a_c01} + r_a_p1[F +: 18];

    // Stage C: y difference times sy.
    assign w_dy = signed'({1'b0, r_b_n1}) - signed'({1'b0, r_b_n0});
    assign w_sy = signed'({1'b0, r_b_sy});
    assign w_py = PW'(w_dy) * PW'(w_sy);

    // Stage D: final add; the result stays within the corner range.
    assign w_sum = {2'b00, r_c_n0} + r_c_py[F +: 18];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a_c00   <= i_c00;
        r_a_c01   <= i_c01;
        r_a_p0    <= w_px0;
        r_a_p1    <= w_px1;
        r_a_sy    <= i_sy;
        r_b_n0    <= w_sum0[VALUE_W-1:0];
        r_b_n1    <= w_sum1[VALUE_W-1:0];
        r_b_sy    <= r_a_sy;
        r_c_n0    <= r_b_n0;
        r_c_py    <= w_py;
        r_d_noise <= w_sum[VALUE_W-1:0];
    end

    assign o_valid       = r_d_valid;
    assign o_noise_value = r_d_noise;

endmodule

@@ hw/rtl/vn2d_checker.sv @@
// ----------------------------------------------------------------------------
// vn2d_checker: port-level checks for the value noise block.
// Watches command beats against result strobes; bound to the top level.
// ----------------------------------------------------------------------------
module vn2d_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [vn2d_pkg::CMD_W-1:0]   i_command,
    input logic                         o_valid,
    input logic [vn2d_pkg::VALUE_W-1:0] o_noise_value
);

    import vn2d_pkg::*;

    logic w_eval_beat;

    assign w_eval_beat = start && !busy && (i_command == CMD_EVAL);

    // The block always takes a beat.
    a_never_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");

    // Every evaluate beat yields a result beat.
    a_eval_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eval_beat |-> ##7 o_valid)
        else $error("evaluate beat lost");

    // Every result stems from an evaluate beat; loads give none.
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_eval_beat, 7))
        else $error("result without evaluate beat, value %0h", o_noise_value);

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

bind value_noise_2d vn2d_checker u_vn2d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_command     (i_command),
    .o_valid       (o_valid),
    .o_noise_value (o_noise_value)
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 2D value noise pipeline.
// Loads both tables, runs a directed set of corner points, then a random mix
// of loads and evaluations. A built-in predictor mirrors the tables and
// computes each noise value. The monitor compares every result beat in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vn2d_pkg::*;

    localparam int TSIZE = TABLE_SIZE_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 213;
    // Value entries filled up front; permutation entries point below this.
    localparam int VALUE_FILL = 64;

    // One command beat as the driver presents it.
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [INDEX_W-1:0]        idx;
        logic [DATA_W-1:0]         data;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_noise_cmd;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        start         = 1'b0;
    logic [CMD_W-1:0]            i_command     = '0;
    logic [INDEX_W-1:0]          i_table_index = '0;
    logic [DATA_W-1:0]           i_table_data  = '0;
    logic signed [COORD_W-1:0]   i_x_coord     = '0;
    logic signed [COORD_W-1:0]   i_y_coord     = '0;
    logic                        busy;
    logic                        o_valid;
    logic [VALUE_W-1:0]          o_noise_value;

    t_noise_cmd         cmd_q[$];
    logic [VALUE_W-1:0] noise_q[$];
    logic [VALUE_W-1:0] value_mem [TSIZE];
    logic [PERM_W-1:0]  perm_mem  [TSIZE];
    logic               took        = 1'b0;
    int                 errors      = 0;
    int                 sent_cnt    = 0;
    int                 total_items = 1;

    value_noise_2d dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_table_index (i_table_index),
        .i_table_data  (i_table_data),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value)
    );

    always #6 i_clk = ~i_clk;

    // Smoothstep of a fraction: t*t*(3-2t) with truncation after each product.
    function automatic logic [63:0] smooth_frac(input logic [63:0] t);
        logic [63:0] t2;
        t2 = (t * t) >> FRAC;
        return (t2 * ((64'd3 << FRAC) - 2 * t)) >> FRAC;
    endfunction

    function automatic logic [63:0] blend(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] s);
        return (a * ((64'd1 << FRAC) - s) + b * s) >> FRAC;
    endfunction

    // Noise value at a point, from the mirrored tables.
    function automatic logic [VALUE_W-1:0] noise_at(input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y);
        logic [63:0] cx0, cx1, cy0, cy1, tx, ty, px0, px1;
        logic [63:0] c00, c10, c01, c11, n0, n1, res;
        cx0 = 64'(x >>> FRAC) & (TSIZE - 1);
        cy0 = 64'(y >>> FRAC) & (TSIZE - 1);
        tx  = 64'(x) & ((64'd1 << FRAC) - 1);
        ty  = 64'(y) & ((64'd1 << FRAC) - 1);
        cx1 = (cx0 + 1) & (TSIZE - 1);
        cy1 = (cy0 + 1) & (TSIZE - 1);
        px0 = 64'(perm_mem[cx0]);
        px1 = 64'(perm_mem[cx1]);
        c00 = 64'(value_mem[64'(perm_mem[(px0 + cy0) & (TSIZE - 1)]) & (TSIZE - 1)]);
        c10 = 64'(value_mem[64'(perm_mem[(px1 + cy0) & (TSIZE - 1)]) & (TSIZE - 1)]);
        c01 = 64'(value_mem[64'(perm_mem[(px0 + cy1) & (TSIZE - 1)]) & (TSIZE - 1)]);
        c11 = 64'(value_mem[64'(perm_mem[(px1 + cy1) & (TSIZE - 1)]) & (TSIZE - 1)]);
        n0  = blend(c00, c10, smooth_frac(tx));
        n1  = blend(c01, c11, smooth_frac(tx));
        res = blend(n0, n1, smooth_frac(ty));
        return res[VALUE_W-1:0];
    endfunction

    function automatic void push_item(input logic [CMD_W-1:0] cmd,
                                      input logic [INDEX_W-1:0] idx,
                                      input logic [DATA_W-1:0] data,
                                      input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y);
        t_noise_cmd item;
        item.cmd  = cmd;
        item.idx  = idx;
        item.data = data;
        item.x    = x;
        item.y    = y;
        cmd_q     = {cmd_q, item};
    endfunction

    // Random coordinate, weighted toward cell edges, small cells and extremes.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
            1: return {r[31:16], 16'h0000};
            2: return {r[31:16], 16'hFFFF - 16'(r[3:0])};
            3: begin
                case (r[1:0])
                    2'd0: return 32'sh7FFF_FFFF;
                    2'd1: return 32'sh8000_0000;
                    2'd2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return r;
        endcase
    endfunction

    // Driver: presents the next beat at the falling edge once the last one was taken.
    always @(negedge i_clk) begin
        int idle_pct;
        t_noise_cmd item;
        if (sent_cnt * 3 < total_items)
            idle_pct = 21;
        else if (sent_cnt * 3 < total_items * 2)
            idle_pct = 53;
        else
            idle_pct = 0;
        if (i_rst_n && (!start || took)) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                item          = cmd_q.pop_front();
                start         <= 1'b1;
                i_command     <= item.cmd;
                i_table_index <= item.idx;
                i_table_data  <= item.data;
                i_x_coord     <= item.x;
                i_y_coord     <= item.y;
                sent_cnt      = sent_cnt + 1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks result beats, then mirrors the beat accepted at this edge.
    always @(posedge i_clk) begin
        logic [VALUE_W-1:0] want;
        took = start && !busy;
        if (i_rst_n) begin
            if (o_valid) begin
                if (noise_q.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t ns: unexpected noise beat, expected none, got %h",
                             $time, o_noise_value);
                end else begin
                    want = noise_q.pop_front();
                    if (o_noise_value !== want) begin
                        errors = errors + 1;
                        $display("%0t ns: noise_value mismatch, expected %h, got %h",
                                 $time, want, o_noise_value);
                    end
                end
            end
            if (took) begin
                case (i_command)
                    CMD_LOAD_VALUE: value_mem[i_table_index] = i_table_data;
                    CMD_LOAD_PERM:  perm_mem[i_table_index] = i_table_data[PERM_W-1:0];
                    CMD_EVAL:       noise_q = {noise_q, noise_at(i_x_coord, i_y_coord)};
                    default: ;
                endcase
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int r;
        // Every permutation entry is written, each pointing into the low value
        // entries, and those value entries are written before any evaluation.
        for (int i = 0; i < TSIZE; i++) begin
            push_item(CMD_LOAD_PERM, INDEX_W'(i), {8'($urandom), 2'b00, 6'($urandom)},
                      $urandom, $urandom);
        end
        for (int i = 0; i < VALUE_FILL; i++) begin
            push_item(CMD_LOAD_VALUE, INDEX_W'(i), 16'($urandom), $urandom, $urandom);
        end

        // Directed corners: zero, extremes, negative floors and wrapping cells.
        push_item(CMD_EVAL, 8'hFF, 16'hFFFF, 32'sh0000_0000, 32'sh0000_0000);
        push_item(CMD_EVAL, 8'h00, 16'h0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_item(CMD_EVAL, 8'h00, 16'h0000, 32'sh8000_0000, 32'sh8000_0000);
        push_item(CMD_EVAL, 8'h00, 16'h0000, -32'sd1, 32'sh0000_8000);
        push_item(CMD_EVAL, 8'h00, 16'h0000, 32'sh00FF_FFFF, -32'sh0001_0000);
        push_item(CMD_EVAL, 8'h00, 16'h0000, 32'sh0000_FFFF, 32'sh00FF_0000);
        push_item(CMD_LOAD_VALUE, 8'h00, 16'hFFFF, 32'sh7FFF_FFFF, -32'sd1);
        // The top value entry is written before a permutation entry points at it.
        push_item(CMD_LOAD_VALUE, 8'hFF, 16'h0000, 32'sh0000_0000, 32'sh0000_0000);
        // Permutation loads with the unused upper data bits set.
        push_item(CMD_LOAD_PERM, 8'h00, 16'hFFFF, 32'sh0000_0000, 32'sh0000_0000);
        push_item(CMD_LOAD_PERM, 8'hFF, 16'h0100, 32'sh0000_0000, 32'sh0000_0000);
        push_item(CMD_EVAL, 8'h00, 16'h0000, 32'shFFFF_0000, 32'sh0000_0000);
        push_item(CMD_EVAL, 8'h00, 16'h0000, 32'sh00FF_8000, 32'sh00FF_8000);
        push_item(CMD_UNUSED, 8'hFF, 16'hFFFF, -32'sd1, -32'sd1);
        push_item(CMD_EVAL, 8'h00, 16'h0000, -32'sd1, -32'sd1);
        push_item(CMD_UNUSED, 8'h00, 16'h0000, 32'sh0000_0000, 32'sh0000_0000);
        push_item(CMD_EVAL, 8'h00, 16'h0000, 32'sh1234_5678, 32'shEDCB_A987);
        push_item(CMD_EVAL, 8'h00, 16'h0000, 32'sh0000_8000, 32'sh0000_0001);

        // Random mix, mostly evaluations with table rewrites in between.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(99);
            if (r < 62)
                push_item(CMD_EVAL, 8'($urandom), 16'($urandom), pick_coord(), pick_coord());
            else if (r < 77)
                push_item(CMD_LOAD_VALUE, 8'($urandom), 16'($urandom), $urandom, $urandom);
            else if (r < 92)
                push_item(CMD_LOAD_PERM, 8'($urandom), {8'($urandom), 2'b00, 6'($urandom)},
                          $urandom, $urandom);
            else
                push_item(CMD_UNUSED, 8'($urandom), 16'($urandom), $urandom, $urandom);
        end
        total_items = cmd_q.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start)
            @(posedge i_clk);
        while (noise_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Watchdog against a hung pipeline.
    initial begin
        #3_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
